// ===== design/sal_pkg.sv =====
package sal_pkg;

    // list geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;
    localparam int VAL_W    = 32;

    // command codes
    typedef enum logic [2:0] {
        CMD_APPEND       = 3'd0,
        CMD_INSERT_AT    = 3'd1,
        CMD_INSERT_AFTER = 3'd2,
        CMD_REMOVE       = 3'd3,
        CMD_READ         = 3'd4
    } cmd_code_t;

    // status codes
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_INDEX = 2'd1,
        STAT_FULL     = 2'd2
    } status_t;

    // controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // request transaction
    typedef struct packed {
        logic [2:0]              command;
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        index;
    } sal_req_t;

    // response transaction
    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] data;
        logic [CNT_W-1:0]        count;
    } sal_rsp_t;

    // controller commands to the datapath
    typedef struct packed {
        logic load;
        logic exec;
    } sal_ctl_t;

endpackage

// ===== design/sal_ctrl.sv =====
module sal_ctrl
    import sal_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output sal_ctl_t ctl
);

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_ready = 1'b0;
        ctl.load  = 1'b0;
        ctl.exec  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                ctl.load  = cmd_valid;
            end
            S_EXEC:
            begin
                ctl.exec = slot_free;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    // response valid flag
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.exec)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    // a finished command always leaves a response waiting
    a_exec_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |=> rsp_valid)
        else $error("executed command produced no response");

    // a response is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.exec && rsp_valid) |-> rsp_ready)
        else $error("pending response overwritten");

    // a loaded transaction is executed before the next one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> !cmd_ready)
        else $error("new transaction accepted before execution");

endmodule

// ===== design/sal_datapath.sv =====
module sal_datapath
    import sal_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  sal_ctl_t ctl,
    input  sal_req_t req,
    output sal_rsp_t rsp
);

    // latched request
    logic [2:0]       cmd_reg;
    logic [VAL_W-1:0] val_reg;
    logic [IDX_W-1:0] idx_reg;

    // list storage and fill count
    logic [VAL_W-1:0] cells_reg  [CAPACITY];
    logic [VAL_W-1:0] cells_next [CAPACITY];
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    sal_rsp_t         rsp_reg;
    sal_rsp_t         rsp_next;

    logic             idx_ok;
    logic             full;
    logic             do_ins;
    logic             do_rem;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] idx_ext;
    logic [VAL_W-1:0] rd_data;

    assign idx_ext = {1'b0, idx_reg};
    assign idx_ok  = idx_ext < fill_reg;
    assign full    = fill_reg == CNT_W'(CAPACITY);
    assign rd_data = cells_reg[idx_reg];

    // command decode and response
    always_comb
    begin
        do_ins            = 1'b0;
        do_rem            = 1'b0;
        pos               = fill_reg;
        fill_next         = fill_reg;
        rsp_next.status   = STAT_OK;
        rsp_next.data     = '0;
        unique case (cmd_reg)
            CMD_APPEND:
            begin
                if (full)
                begin
                    rsp_next.status = STAT_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                    pos    = fill_reg;
                end
            end
            CMD_INSERT_AT, CMD_INSERT_AFTER:
            begin
                if (!idx_ok)
                begin
                    rsp_next.status = STAT_NO_INDEX;
                end
                else if (full)
                begin
                    rsp_next.status = STAT_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                    pos    = (cmd_reg == CMD_INSERT_AT) ? idx_ext : idx_ext + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (!idx_ok)
                begin
                    rsp_next.status = STAT_NO_INDEX;
                end
                else
                begin
                    do_rem        = 1'b1;
                    rsp_next.data = rd_data;
                end
            end
            CMD_READ:
            begin
                if (!idx_ok)
                begin
                    rsp_next.status = STAT_NO_INDEX;
                end
                else
                begin
                    rsp_next.data = rd_data;
                end
            end
            default:
            begin
                rsp_next.status = STAT_OK;
            end
        endcase
        if (do_ins)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (do_rem)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
        rsp_next.count = fill_next;
    end

    // row of cells shifting up on insert, down on remove
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VAL_W-1:0] below;
        logic [VAL_W-1:0] above;
        if (i == 0)
        begin : g_first
            assign below = cells_reg[i];
        end
        else
        begin : g_rest
            assign below = cells_reg[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign above = cells_reg[i];
        end
        else
        begin : g_mid
            assign above = cells_reg[i+1];
        end

        always_comb
        begin
            cells_next[i] = cells_reg[i];
            if (do_ins)
            begin
                if (CNT_W'(i) == pos)
                begin
                    cells_next[i] = val_reg;
                end
                else if (CNT_W'(i) > pos)
                begin
                    cells_next[i] = below;
                end
            end
            else if (do_rem && (CNT_W'(i) >= idx_ext))
            begin
                cells_next[i] = above;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= req.command;
            val_reg <= req.value;
            idx_reg <= req.index;
        end
        if (ctl.exec)
        begin
            rsp_reg <= rsp_next;
            for (int j = 0; j < CAPACITY; j++)
            begin
                cells_reg[j] <= cells_next[j];
            end
        end
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (ctl.exec)
        begin
            fill_reg <= fill_next;
        end
    end

    assign rsp = rsp_reg;

    // fill count stays within capacity
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // one command moves the fill count by at most one
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |=> (fill_reg == $past(fill_reg))
                  || (fill_reg == $past(fill_reg) + CNT_W'(1))
                  || (fill_reg + CNT_W'(1) == $past(fill_reg)))
        else $error("fill count jumped");

    // reported count matches the stored fill count
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |=> rsp.count == fill_reg)
        else $error("response count differs from fill count");

endmodule

// ===== design/sequential_array_list_core.sv =====
// a command is accepted and latched by the load step of the controller in S_IDLE, and is
// executed in S_EXEC, where its response is registered; a new command is not taken until
// the last one has executed, and a response left waiting stalls execution until it is taken
// reset: rst_n clears the controller and the fill count, list cells are left unknown
module sequential_array_list_core
    import sal_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  sal_req_t cmd,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output sal_rsp_t rsp
);

    sal_ctl_t ctl;

    // controller
    sal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ctl       (ctl)
    );

    // list datapath
    sal_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .req   (cmd),
        .rsp   (rsp)
    );

endmodule
